@@ rtl/core/irpwd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the infrared pulse-width decoder: beat types, event codes,
// phase codes and the pulse-window bounds in timer ticks. No dependencies.

package irpwd_pkg;

    localparam int TICKS_PER_US = 48;

    typedef enum logic [1:0] {
        OP_RISE = 2'd0,
        OP_FALL = 2'd1,
        OP_WRAP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_LEAD_MRK = 5'b00010,
        PH_LEAD_SPC = 5'b00100,
        PH_BIT_MRK  = 5'b01000,
        PH_BIT_SPC  = 5'b10000
    } phase_t;

    localparam logic [2:0] PHN_IDLE     = 3'd0;
    localparam logic [2:0] PHN_LEAD_MRK = 3'd1;
    localparam logic [2:0] PHN_LEAD_SPC = 3'd2;
    localparam logic [2:0] PHN_BIT_MRK  = 3'd3;
    localparam logic [2:0] PHN_BIT_SPC  = 3'd4;

    // Window bounds on raw tick differences: floor(d / T) >= A is d >= A*T,
    // floor(d / T) <= B is d < (B+1)*T.
    localparam logic [31:0] LEAD_MARK_MIN = 32'(7000 * TICKS_PER_US);
    localparam logic [31:0] LEAD_MARK_LIM = 32'(12001 * TICKS_PER_US);
    localparam logic [31:0] FRAME_SPC_MIN = 32'(4201 * TICKS_PER_US);
    localparam logic [31:0] FRAME_SPC_LIM = 32'(4701 * TICKS_PER_US);
    localparam logic [31:0] RPT_SPC_MIN   = 32'(2201 * TICKS_PER_US);
    localparam logic [31:0] RPT_SPC_LIM   = 32'(2601 * TICKS_PER_US);
    localparam logic [31:0] ZERO_SPC_MIN  = 32'(301 * TICKS_PER_US);
    localparam logic [31:0] ZERO_SPC_LIM  = 32'(800 * TICKS_PER_US);
    localparam logic [31:0] ONE_SPC_MIN   = 32'(1401 * TICKS_PER_US);
    localparam logic [31:0] ONE_SPC_LIM   = 32'(1800 * TICKS_PER_US);

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] capture_value;
    } irpwd_in_t;

    typedef struct packed {
        logic [2:0] phase_now;
        logic       frame_start;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_position;
        logic       repeat_seen;
        logic [7:0] repeat_total;
    } irpwd_out_t;

    function automatic logic [2:0] phase_code(phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:     code = PHN_IDLE;
            PH_LEAD_MRK: code = PHN_LEAD_MRK;
            PH_LEAD_SPC: code = PHN_LEAD_SPC;
            PH_BIT_MRK:  code = PHN_BIT_MRK;
            PH_BIT_SPC:  code = PHN_BIT_SPC;
            default:     code = PHN_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/ir_pulse_width_decoder_top.sv @@
`timescale 1ns / 1ps
// Infrared pulse-width decoder: input register, decode logic and result register.
// Depends on irpwd_pkg.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+-----------------------------------
//  in      | in        | in_valid / in_stall | irpwd_in_t: event kind, capture
//  out     | out       | out_valid/out_stall | irpwd_out_t: phase, flags, byte
//  cfg     | in        | cfg_valid/cfg_ready | 32-bit counter wrap period
//
// An event waits in the input register while the subtract-and-compare path works
// on it, then moves into the result register, which raises out_valid. One event
// per cycle is sustained while the output is not stalled; the decoder state
// updates as the event moves into the result register.
// rst_n clears the valid flags and all decoder state at once and sets the period to all ones. A stall at the output
// holds the result and backs up into in_stall only when both registers are full.
// cfg_ready is always high.

module ir_pulse_width_decoder_top
    import irpwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  irpwd_in_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output irpwd_out_t  out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic        in_vld_reg;
    irpwd_in_t   in_beat_reg;
    logic        out_vld_reg;
    irpwd_out_t  out_beat_reg;
    irpwd_out_t  out_beat_next;

    logic [31:0] period_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] mark_start_reg, mark_start_next;
    logic [31:0] lead_end_reg, lead_end_next;
    logic [31:0] bit_ref_reg, bit_ref_next;
    logic [31:0] offset_reg, offset_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bits_reg, bits_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  rpt_cnt_reg, rpt_cnt_next;

    logic        out_room;
    logic        fire;
    logic        in_take;
    op_t         op;
    logic [31:0] cap;
    logic [31:0] ref_time;
    logic [31:0] delta;
    logic [7:0]  shifted;
    logic        bit_val;

    assign out_room  = !out_vld_reg || !out_stall;
    assign fire      = in_vld_reg && out_room;
    assign in_stall  = in_vld_reg && !out_room;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;
    assign cfg_ready = 1'b1;

    assign op  = op_t'(in_beat_reg.operation);
    assign cap = in_beat_reg.capture_value;

    always_comb
    begin
        unique case (phase_reg)
            PH_LEAD_MRK: ref_time = mark_start_reg;
            PH_LEAD_SPC: ref_time = lead_end_reg;
            default:     ref_time = bit_ref_reg;
        endcase
    end

    assign delta = cap + offset_reg - ref_time;

    always_comb
    begin
        phase_next      = phase_reg;
        mark_start_next = mark_start_reg;
        lead_end_next   = lead_end_reg;
        bit_ref_next    = bit_ref_reg;
        offset_next     = offset_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        byte_cnt_next   = byte_cnt_reg;
        rpt_cnt_next    = rpt_cnt_reg;
        bit_val         = (delta >= ONE_SPC_MIN) && (delta < ONE_SPC_LIM);
        shifted         = {shift_reg[6:0], bit_val};
        out_beat_next   = '0;

        case (op)
            OP_RISE:
            begin
                if (phase_reg == PH_LEAD_MRK)
                begin
                    lead_end_next = cap;
                    if ((delta >= LEAD_MARK_MIN) && (delta < LEAD_MARK_LIM))
                    begin
                        phase_next  = PH_LEAD_SPC;
                        offset_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else if (phase_reg == PH_BIT_MRK)
                begin
                    bit_ref_next = cap;
                    offset_next  = '0;
                    phase_next   = PH_BIT_SPC;
                end
            end
            OP_FALL:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    mark_start_next = cap;
                    offset_next     = '0;
                    phase_next      = PH_LEAD_MRK;
                end
                else if (phase_reg == PH_LEAD_SPC)
                begin
                    offset_next = '0;
                    if ((delta >= FRAME_SPC_MIN) && (delta < FRAME_SPC_LIM))
                    begin
                        phase_next                = PH_BIT_MRK;
                        byte_cnt_next             = '0;
                        out_beat_next.frame_start = 1'b1;
                    end
                    else if ((delta >= RPT_SPC_MIN) && (delta < RPT_SPC_LIM))
                    begin
                        rpt_cnt_next              = rpt_cnt_reg + 8'd1;
                        out_beat_next.repeat_seen = 1'b1;
                        phase_next                = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else if (phase_reg == PH_BIT_SPC)
                begin
                    if (bit_val || ((delta >= ZERO_SPC_MIN) && (delta < ZERO_SPC_LIM)))
                    begin
                        phase_next = PH_BIT_MRK;
                        if (bits_reg == 3'd7)
                        begin
                            out_beat_next.byte_valid    = 1'b1;
                            out_beat_next.byte_value    = shifted;
                            out_beat_next.byte_position = byte_cnt_reg;
                            byte_cnt_next               = byte_cnt_reg + 8'd1;
                            bits_next                   = '0;
                            shift_next                  = '0;
                        end
                        else
                        begin
                            shift_next = shifted;
                            bits_next  = bits_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            OP_WRAP:
            begin
                offset_next = offset_reg + period_reg;
            end
            default:
            begin
            end
        endcase

        out_beat_next.phase_now    = phase_code(phase_next);
        out_beat_next.repeat_total = rpt_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            period_reg     <= '1;
            phase_reg      <= PH_IDLE;
            mark_start_reg <= '0;
            lead_end_reg   <= '0;
            bit_ref_reg    <= '0;
            offset_reg     <= '0;
            shift_reg      <= '0;
            bits_reg       <= '0;
            byte_cnt_reg   <= '0;
            rpt_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (out_room)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                mark_start_reg <= mark_start_next;
                lead_end_reg   <= lead_end_next;
                bit_ref_reg    <= bit_ref_next;
                offset_reg     <= offset_next;
                shift_reg      <= shift_next;
                bits_reg       <= bits_next;
                byte_cnt_reg   <= byte_cnt_next;
                rpt_cnt_reg    <= rpt_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_beat_reg <= in_data;
        end
        if (fire)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled with room downstream");

    a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.byte_valid) |-> (out_data.phase_now == PHN_BIT_MRK))
        else $error("byte emitted outside bit phase");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.frame_start && out_data.repeat_seen))
        else $error("frame start and repeat in one beat");

    a_rpt_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rpt_cnt_reg == ($past(rpt_cnt_reg)
                  + {7'd0, out_beat_reg.repeat_seen})))
        else $error("repeat count out of step with repeat flag");
`endif

endmodule
